// File: rtl/lrsgd_pkg.sv
// ----------------------------------------------------------------------------
// lrsgd_pkg
// Shared types and constants of the logistic regression SGD engine.
// ----------------------------------------------------------------------------
package lrsgd_pkg;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_FEAT  = 3'd1;
  localparam logic [2:0] OP_CLOSE = 3'd2;
  localparam logic [2:0] OP_APPLY = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_RATE      = 1'b1;

  localparam logic KIND_PRED = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         element_index;
    logic signed [31:0] weight_value;
    logic signed [15:0] feature_value;
    logic               train_mode;
    logic               true_label;
    logic               last_feature;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic               predicted_label;
    logic signed [55:0] dot_product;
    logic signed [31:0] weight_out;
  } out_item_t;

endpackage

// File: rtl/lrsgd_div.sv
// ----------------------------------------------------------------------------
// lrsgd_div
// Restoring divider, one quotient bit per cycle, signed dividend and
// unsigned divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module lrsgd_div #(
  parameter int NumW = 48,
  parameter int DenW = 21
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [DenW-1:0]        den_i,
  output logic                   done_o,
  output logic signed [NumW-1:0] quo_o
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] mag_q, mag_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic            neg_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, done_q;
  logic [DenW:0]   trial;

  always_comb begin
    trial = {rem_q[DenW-1:0], mag_q[NumW-1]};
    rem_d = trial;
    mag_d = {mag_q[NumW-2:0], 1'b0};
    if (trial >= {1'b0, den_q}) begin
      rem_d = trial - {1'b0, den_q};
      mag_d[0] = 1'b1;
    end
    cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(NumW);
      end else if (run_q) begin
        cnt_q <= cnt_d;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= num_i[NumW-1] ? NumW'(-num_i) : num_i;
      neg_q <= num_i[NumW-1];
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(mag_q) : $signed(mag_q);
endmodule

// File: rtl/logistic_regression_sgd_engine_unit.sv
// ----------------------------------------------------------------------------
// logistic_regression_sgd_engine_unit
// Logistic regression classifier with mini-batch SGD weight training.
// ----------------------------------------------------------------------------
// Usage: present an item on in_item_i with start high; it is accepted at the
// rising edge where busy is low. Load keeps busy low, so loads can follow
// back to back. Read passes through the busy state S_READ, which registers
// its result strobe. A feature passes through the busy states S_FEAT (feature
// store and multiply) and S_MAC (accumulate) before the next can be accepted.
// A last feature adds S_PRED, which registers its prediction strobe. A
// training record then walks len_q entries (highest feature index plus one)
// of the gradient memory, through S_TRD and S_TWR for each entry. Close batch
// walks all entries, each through read, divider start, serial divide and
// write back. Apply update walks all entries through S_ARD, S_AM1, S_AM2 and
// S_AWR. Results appear on out_item_o for one cycle marked by out_valid_o;
// the receiver cannot stall. After reset a clearing pass over all entries
// zeroes weights, gradients and steps; busy is high during it. cfg_we_i
// writes a register only while idle; the user, not the block, ensures this.
// ----------------------------------------------------------------------------
module logistic_regression_sgd_engine_unit #(
  parameter int MAX_FEATURES = 256,
  parameter int MAX_BATCH    = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lrsgd_pkg::in_item_t in_item_i,
  output logic                out_valid_o,
  output lrsgd_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  localparam int AW   = (MAX_FEATURES > 256) ? 8 : $clog2(MAX_FEATURES);
  localparam int NE   = (MAX_FEATURES > 256) ? 256 : MAX_FEATURES;
  localparam int LW   = AW + 1;
  localparam int CW   = $clog2(MAX_BATCH + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FEAT, S_MAC, S_PRED, S_TRD, S_TWR,
    S_CRD, S_CST, S_CDIV, S_CWR, S_ARD, S_AM1, S_AM2, S_AWR, S_READ
  } state_e;

  state_e state_q;
  lrsgd_pkg::in_item_t item_q;
  logic signed [31:0] thr_q;
  logic [31:0]        rate_q;

  logic signed [31:0] wmem [NE];
  logic signed [15:0] fmem [NE];
  logic signed [31:0] gmem [NE];
  logic signed [47:0] smem [NE];
  logic signed [31:0] w_rd_q, g_rd_q;
  logic signed [15:0] f_rd_q;
  logic signed [47:0] s_rd_q;

  logic [AW-1:0]      ptr_q;
  logic signed [55:0] dot_q;
  logic [LW-1:0]      len_q;
  logic [CW-1:0]      cnt_q;
  logic signed [1:0]  err_q;
  logic signed [47:0] prod_q;
  logic [63:0]        m1_q;
  logic [47:0]        mag_q;
  logic               sneg_q;
  logic               out_v_q;
  lrsgd_pkg::out_item_t out_q;

  logic               div_start, div_done;
  logic signed [47:0] div_q;

  logic ok;
  assign ok = ({24'd0, item_q.element_index} < 32'(MAX_FEATURES));
  wire [AW-1:0] iidx = AW'(item_q.element_index);

  lrsgd_div #(.NumW(48), .DenW(CW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i({g_rd_q, 16'd0}), .den_i(cnt_q),
    .done_o(div_done), .quo_o(div_q)
  );
  assign div_start = (state_q == S_CST);

  logic signed [57:0] dsum;
  logic signed [33:0] gsum;
  logic signed [48:0] ssum;
  logic signed [34:0] wdiff;
  logic [33:0]        dlt;
  logic signed [55:0] dot_n;
  assign dsum  = 58'(dot_q) + 58'(prod_q);
  assign dot_n = (dsum > 58'sh7FFFFFFFFFFFFF) ? 56'sh7FFFFFFFFFFFFF :
                 (dsum < -58'sh80000000000000) ? -56'sh80000000000000 : 56'(dsum);
  assign gsum  = 34'(g_rd_q) + 34'(err_q) * 34'(f_rd_q);
  assign ssum  = 49'(s_rd_q) + 49'(div_q);
  always_comb begin
    logic [64:0] d;
    d = 65'(m1_q >> 16) + 65'(mag_q) * 65'(rate_q[31:16]);
    dlt = (d > 65'h200000000) ? 34'h200000000 : 34'(d);
  end
  assign wdiff = 35'(w_rd_q) - (sneg_q ? -35'($signed({1'b0, dlt})) : 35'($signed({1'b0, dlt})));

  logic pred;
  assign pred = (dot_q >= 56'(thr_q));

  always_ff @(posedge clk_i) begin
    w_rd_q <= wmem[(state_q == S_IDLE) ? AW'(in_item_i.element_index) : ptr_q];
    f_rd_q <= fmem[ptr_q];
    g_rd_q <= gmem[ptr_q];
    s_rd_q <= smem[ptr_q];
    if (state_q == S_CLEAR) begin
      wmem[ptr_q] <= '0; gmem[ptr_q] <= '0; smem[ptr_q] <= '0;
    end
    if (state_q == S_IDLE && start && in_item_i.opcode == lrsgd_pkg::OP_LOAD &&
        {24'd0, in_item_i.element_index} < 32'(MAX_FEATURES))
      wmem[AW'(in_item_i.element_index)] <= in_item_i.weight_value;
    if (state_q == S_FEAT && ok) fmem[iidx] <= item_q.feature_value;
    if (state_q == S_TWR)
      gmem[ptr_q] <= (gsum > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                     (gsum < -34'sh80000000) ? -32'sh80000000 : 32'(gsum);
    if (state_q == S_CWR) begin
      gmem[ptr_q] <= '0;
      smem[ptr_q] <= (ssum > 49'sh7FFFFFFFFFFF) ? 48'sh7FFFFFFFFFFF :
                     (ssum < -49'sh800000000000) ? -48'sh800000000000 : 48'(ssum);
    end
    if (state_q == S_AWR) begin
      smem[ptr_q] <= '0;
      wmem[ptr_q] <= (wdiff > 35'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                     (wdiff < -35'sh80000000) ? -32'sh80000000 : 32'(wdiff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; ptr_q <= '0; dot_q <= '0; len_q <= '0; cnt_q <= '0;
      thr_q <= '0; rate_q <= 32'd655; out_v_q <= 1'b0;
      item_q <= '0; out_q <= '0; prod_q <= '0; err_q <= '0;
      sneg_q <= 1'b0; mag_q <= '0; m1_q <= '0;
    end else begin
      out_v_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == lrsgd_pkg::CFG_THRESHOLD) thr_q <= cfg_data_i;
        else rate_q <= cfg_data_i;
      end
      case (state_q)
        S_CLEAR: begin
          ptr_q <= ptr_q + AW'(1);
          if (ptr_q == AW'(NE - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (start) begin
          item_q <= in_item_i;
          ptr_q  <= '0;
          case (in_item_i.opcode)
            lrsgd_pkg::OP_FEAT:  state_q <= S_FEAT;
            lrsgd_pkg::OP_CLOSE: if (cnt_q != '0) state_q <= S_CRD;
            lrsgd_pkg::OP_APPLY: state_q <= S_ARD;
            lrsgd_pkg::OP_READ:  state_q <= S_READ;
            default: ;
          endcase
        end
        S_READ: begin
          out_v_q <= 1'b1;
          out_q   <= '{lrsgd_pkg::KIND_READ, 1'b0, 56'sd0, ok ? w_rd_q : 32'sd0};
          state_q <= S_IDLE;
        end
        S_FEAT: begin
          prod_q <= ok ? 48'(w_rd_q * item_q.feature_value) : '0;
          if (ok && LW'(iidx) + LW'(1) > len_q) len_q <= LW'(iidx) + LW'(1);
          state_q <= S_MAC;
        end
        S_MAC: begin
          dot_q <= dot_n;
          state_q <= item_q.last_feature ? S_PRED : S_IDLE;
        end
        S_PRED: begin
          out_v_q <= 1'b1;
          out_q   <= '{lrsgd_pkg::KIND_PRED, pred, dot_q, 32'sd0};
          err_q   <= 2'(pred) - 2'(item_q.true_label);
          dot_q   <= '0;
          if (item_q.train_mode && cnt_q < CW'(MAX_BATCH)) begin
            cnt_q <= cnt_q + CW'(1);
            state_q <= (len_q != '0) ? S_TRD : S_IDLE;
            if (len_q == '0) len_q <= '0;
          end else begin
            len_q <= '0; state_q <= S_IDLE;
          end
        end
        S_TRD: state_q <= S_TWR;
        S_TWR: begin
          ptr_q <= ptr_q + AW'(1);
          if (LW'(ptr_q) + LW'(1) == len_q) begin
            len_q <= '0; state_q <= S_IDLE;
          end else state_q <= S_TRD;
        end
        S_CRD: state_q <= S_CST;
        S_CST: state_q <= S_CDIV;
        S_CDIV: if (div_done) state_q <= S_CWR;
        S_CWR: begin
          ptr_q <= ptr_q + AW'(1);
          if (ptr_q == AW'(NE - 1)) begin
            cnt_q <= '0; state_q <= S_IDLE;
          end else state_q <= S_CRD;
        end
        S_ARD: state_q <= S_AM1;
        S_AM1: begin
          sneg_q <= s_rd_q[47];
          mag_q  <= s_rd_q[47] ? 48'(-s_rd_q) : s_rd_q;
          state_q <= S_AM2;
        end
        S_AM2: begin
          m1_q <= 64'(mag_q) * 64'(rate_q[15:0]);
          state_q <= S_AWR;
        end
        S_AWR: begin
          ptr_q <= ptr_q + AW'(1);
          state_q <= (ptr_q == AW'(NE - 1)) ? S_IDLE : S_ARD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;
endmodule

// File: rtl/lrsgd_checker.sv
// ----------------------------------------------------------------------------
// lrsgd_checker
// Port-level checks of the SGD engine.
// ----------------------------------------------------------------------------
module lrsgd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input lrsgd_pkg::in_item_t  in_item_i,
  input logic                 out_valid_o,
  input lrsgd_pkg::out_item_t out_item_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (in_item_i.opcode == lrsgd_pkg::OP_FEAT ||
                       in_item_i.opcode == lrsgd_pkg::OP_READ) |=> busy)
    else $error("accept did not raise busy");
  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o) else $error("result strobe too long");
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind == lrsgd_pkg::KIND_READ |->
    out_item_o.dot_product == '0) else $error("read carries dot");
  a_pred_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind == lrsgd_pkg::KIND_PRED |->
    out_item_o.weight_out == '0) else $error("prediction carries weight");
endmodule

bind logistic_regression_sgd_engine_unit lrsgd_checker u_chk (.*);
